// ===== rtl/trnr_pkg.sv =====
// Shared types and constants for the torus rank node reorder block.
package trnr_pkg;

    localparam int RANK_W    = 20;
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int DU_W      = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DIMS_USED          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_LENGTHS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_LOCAL_LENGTHS = 2'd2;

    localparam logic CMD_FORWARD = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    localparam logic [DU_W-1:0]   RST_DIMS_USED = 4'd1;
    localparam logic [CFG_W-1:0]  RST_LENGTHS   = 64'h0101_0101_0101_0101;
    localparam logic [RANK_W-1:0] STRIDE_SAT    = 20'hFFFFF;

    typedef struct packed {
        logic              command;
        logic [RANK_W-1:0] rank_in;
    } req_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank_out;
        logic              config_error;
    } rsp_t;

    typedef struct packed {
        logic start;
        logic short_op;
    } div_ctl_t;

endpackage

// ===== rtl/trnr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module trnr_div #(
    parameter int DIVW     = 21,
    parameter int LEN_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  trnr_pkg::div_ctl_t             ctl,
    input  logic [trnr_pkg::RANK_W-1:0]    dividend,
    input  logic [DIVW-1:0]                divisor,
    output logic                           done,
    output logic [trnr_pkg::RANK_W-1:0]    quotient,
    output logic [DIVW-1:0]                remainder
);

    localparam int RW    = trnr_pkg::RANK_W;
    localparam int CNT_W = $clog2(RW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIVW-1:0]  rem_reg;
    logic [RW-1:0]    dvd_reg;
    logic [DIVW-1:0]  dsr_reg;

    logic [DIVW:0]    trial;
    logic [DIVW:0]    diff;
    logic             ge;
    logic [DIVW-1:0]  rem_step;

    // Short operations carry a value of at most LEN_BITS bits, aligned to the top.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[RW-1]};
        diff     = trial - {1'b0, dsr_reg};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_step = ge ? diff[DIVW-1:0] : trial[DIVW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctl.short_op ? CNT_W'(LEN_BITS) : CNT_W'(RW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            dvd_reg <= ctl.short_op ? (dividend << (RW - LEN_BITS)) : dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[RW-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/torus_rank_node_reorder.sv =====
// Top level of the torus rank node reorder block: registers, sequencer and result stage.
//
// This block remaps a 20-bit process rank between node-major order (command 0) and
// torus order (command 1) for a torus of up to MAX_DIMS dimensions, each dimension
// length split into an on-node factor and a node-count factor. It accepts one request
// at a time and raises config_error, with rank_out zero, when a factor is zero or does
// not divide its length, when the product of the lengths exceeds 2^RANK_BITS, or when
// the rank is out of range. All divisions run on one shared restoring divider that
// retires one quotient bit per cycle, and that divider sets the pace of a request;
// a flagged request ends early. The validation pass runs once per request, and
// dimension strides are rebuilt on the fly from the lengths. A finished result sits
// in an output register, so the next request is taken while it waits to be collected.
// Registers are written through a plain write port and must only be written while the
// block is idle; a write to an unknown index is ignored.
module torus_rank_node_reorder #(
    parameter int MAX_DIMS  = 8,
    parameter int LEN_BITS  = 8,
    parameter int RANK_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  trnr_pkg::req_t                      req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output trnr_pkg::rsp_t                      rsp_data,
    input  logic                                cfg_we,
    input  logic [trnr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [trnr_pkg::CFG_W-1:0]          cfg_data
);

    localparam int RW    = trnr_pkg::RANK_W;
    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    // Products of lengths run up to 2^RANK_BITS, so they need one bit more.
    localparam int PRW   = RANK_BITS + 1;
    localparam int DIVW  = (PRW > LEN_BITS) ? PRW : LEN_BITS;
    localparam int MW    = PRW + LEN_BITS;
    localparam int CMPW  = (PRW > RW) ? PRW : RW;
    localparam int SMW   = RW + LEN_BITS;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_CHK_WAIT,
        S_RANGE,
        S_F_SPLIT,
        S_F_NODE_GO,
        S_F_NODE,
        S_F_LOC_GO,
        S_F_LOC,
        S_F_DIG,
        S_F_ACC,
        S_I_L_GO,
        S_I_L,
        S_I_P_GO,
        S_I_P,
        S_I_ACC,
        S_I_FIN,
        S_OUT
    } state_t;

    // Configuration registers.
    logic [trnr_pkg::DU_W-1:0]  dims_used_reg;
    logic [trnr_pkg::CFG_W-1:0] dim_lengths_reg;
    logic [trnr_pkg::CFG_W-1:0] node_local_lengths_reg;

    // Sequencer and result stage.
    state_t          state_reg,     state_next;
    logic            rsp_valid_reg, rsp_valid_next;
    trnr_pkg::rsp_t  rsp_data_reg,  rsp_data_next;

    // Working registers.
    logic                cmd_reg,    cmd_next;
    logic                err_reg,    err_next;
    logic [DIM_W-1:0]    dim_reg,    dim_next;
    logic [RW-1:0]       rank_reg,   rank_next;
    logic [PRW-1:0]      prod_reg,   prod_next;
    logic [PRW-1:0]      nl_reg,     nl_next;
    logic [RW-1:0]       node_reg,   node_next;
    logic [RW-1:0]       loc_reg,    loc_next;
    logic [RW-1:0]       acc_reg,    acc_next;
    logic [RW-1:0]       nacc_reg,   nacc_next;
    logic [RW-1:0]       wl_reg,     wl_next;
    logic [RW-1:0]       wn_reg,     wn_next;
    logic [RW-1:0]       stride_reg, stride_next;
    logic [LEN_BITS-1:0] hi_reg,     hi_next;
    logic [LEN_BITS-1:0] lo_reg,     lo_next;
    logic [LEN_BITS-1:0] digit_reg,  digit_next;
    logic [LEN_BITS-1:0] q_reg [MAX_DIMS];
    logic                q_we;

    // Per-dimension factors of the dimension under work.
    logic [LEN_BITS-1:0] len_arr [MAX_DIMS];
    logic [LEN_BITS-1:0] fac_arr [MAX_DIMS];
    logic [LEN_BITS-1:0] len_cur;
    logic [LEN_BITS-1:0] fac_cur;
    logic [LEN_BITS-1:0] q_cur;
    logic [DIM_W-1:0]    last_dim;

    logic [MW-1:0]       prod_mul;
    logic [MW-1:0]       nl_mul;
    logic [MW-1:0]       limit;
    logic [SMW-1:0]      stride_mul;
    logic [2*LEN_BITS-1:0] digit_mul;

    // Shared divider.
    trnr_pkg::div_ctl_t  div_ctl;
    logic [RW-1:0]       div_dividend;
    logic [DIVW-1:0]     div_divisor;
    logic                div_done;
    logic [RW-1:0]       div_quo;
    logic [DIVW-1:0]     div_rem;

    trnr_div #(
        .DIVW     (DIVW),
        .LEN_BITS (LEN_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Byte i of each length register holds dimension i; only its low LEN_BITS count.
    always_comb
    begin
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            len_arr[i] = dim_lengths_reg[trnr_pkg::BYTE_W*i +: LEN_BITS];
            fac_arr[i] = node_local_lengths_reg[trnr_pkg::BYTE_W*i +: LEN_BITS];
        end
    end

    assign len_cur = len_arr[dim_reg];
    assign fac_cur = fac_arr[dim_reg];
    assign q_cur   = q_reg[dim_reg];

    // A dimension count of zero acts as one, and one above MAX_DIMS acts as MAX_DIMS.
    always_comb
    begin
        if (dims_used_reg == '0)
        begin
            last_dim = '0;
        end
        else if (dims_used_reg > trnr_pkg::DU_W'(MAX_DIMS))
        begin
            last_dim = DIM_W'(MAX_DIMS - 1);
        end
        else
        begin
            last_dim = DIM_W'(dims_used_reg - trnr_pkg::DU_W'(1));
        end
    end

    assign prod_mul   = MW'(prod_reg) * MW'(len_cur);
    assign nl_mul     = MW'(nl_reg) * MW'(fac_cur);
    assign limit      = MW'(1) << RANK_BITS;
    assign stride_mul = SMW'(stride_reg) * SMW'(len_cur);
    assign digit_mul  = (2*LEN_BITS)'(hi_reg) * (2*LEN_BITS)'(fac_cur);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Sequencer: validation pass, then the forward or the inverse digit loop.
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        cmd_next       = cmd_reg;
        err_next       = err_reg;
        dim_next       = dim_reg;
        rank_next      = rank_reg;
        prod_next      = prod_reg;
        nl_next        = nl_reg;
        node_next      = node_reg;
        loc_next       = loc_reg;
        acc_next       = acc_reg;
        nacc_next      = nacc_reg;
        wl_next        = wl_reg;
        wn_next        = wn_reg;
        stride_next    = stride_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        digit_next     = digit_reg;
        q_we           = 1'b0;
        div_ctl        = '0;
        div_dividend   = '0;
        div_divisor    = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req_data.command;
                    rank_next  = req_data.rank_in;
                    err_next   = 1'b0;
                    dim_next   = '0;
                    prod_next  = PRW'(1);
                    nl_next    = PRW'(1);
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                if (len_cur == '0 || fac_cur == '0)
                begin
                    err_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    div_ctl.start    = 1'b1;
                    div_ctl.short_op = 1'b1;
                    div_dividend     = RW'(len_cur);
                    div_divisor      = DIVW'(fac_cur);
                    state_next       = S_CHK_WAIT;
                end
            end

            S_CHK_WAIT:
            begin
                if (div_done)
                begin
                    q_we      = 1'b1;
                    prod_next = PRW'(prod_mul);
                    nl_next   = PRW'(nl_mul);
                    if (div_rem != '0 || prod_mul > limit)
                    begin
                        err_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (dim_reg == last_dim)
                    begin
                        state_next = S_RANGE;
                    end
                    else
                    begin
                        dim_next   = dim_reg + DIM_W'(1);
                        state_next = S_CHK;
                    end
                end
            end

            S_RANGE:
            begin
                dim_next    = '0;
                acc_next    = '0;
                nacc_next   = '0;
                stride_next = RW'(1);
                wl_next     = RW'(1);
                wn_next     = RW'(1);
                if (CMPW'(rank_reg) >= CMPW'(prod_reg))
                begin
                    err_next   = 1'b1;
                    state_next = S_OUT;
                end
                else if (cmd_reg == trnr_pkg::CMD_FORWARD)
                begin
                    // Split into the node part and the on-node part.
                    div_ctl.start = 1'b1;
                    div_dividend  = rank_reg;
                    div_divisor   = DIVW'(nl_reg);
                    state_next    = S_F_SPLIT;
                end
                else
                begin
                    state_next = S_I_L_GO;
                end
            end

            S_F_SPLIT:
            begin
                if (div_done)
                begin
                    node_next  = div_quo;
                    loc_next   = RW'(div_rem);
                    state_next = S_F_NODE_GO;
                end
            end

            S_F_NODE_GO:
            begin
                div_ctl.start = 1'b1;
                div_dividend  = node_reg;
                div_divisor   = DIVW'(q_cur);
                state_next    = S_F_NODE;
            end

            S_F_NODE:
            begin
                if (div_done)
                begin
                    hi_next    = LEN_BITS'(div_rem);
                    node_next  = div_quo;
                    state_next = S_F_LOC_GO;
                end
            end

            S_F_LOC_GO:
            begin
                div_ctl.start = 1'b1;
                div_dividend  = loc_reg;
                div_divisor   = DIVW'(fac_cur);
                state_next    = S_F_LOC;
            end

            S_F_LOC:
            begin
                if (div_done)
                begin
                    lo_next    = LEN_BITS'(div_rem);
                    loc_next   = div_quo;
                    state_next = S_F_DIG;
                end
            end

            S_F_DIG:
            begin
                // The torus digit stays below the dimension length.
                digit_next = LEN_BITS'(digit_mul + (2*LEN_BITS)'(lo_reg));
                state_next = S_F_ACC;
            end

            S_F_ACC:
            begin
                acc_next    = acc_reg + RW'(digit_reg) * stride_reg;
                stride_next = (stride_mul > SMW'(trnr_pkg::STRIDE_SAT)) ?
                              trnr_pkg::STRIDE_SAT : RW'(stride_mul);
                if (dim_reg == last_dim)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    dim_next   = dim_reg + DIM_W'(1);
                    state_next = S_F_NODE_GO;
                end
            end

            S_I_L_GO:
            begin
                div_ctl.start = 1'b1;
                div_dividend  = rank_reg;
                div_divisor   = DIVW'(len_cur);
                state_next    = S_I_L;
            end

            S_I_L:
            begin
                if (div_done)
                begin
                    rank_next  = div_quo;
                    lo_next    = LEN_BITS'(div_rem);
                    state_next = S_I_P_GO;
                end
            end

            S_I_P_GO:
            begin
                div_ctl.start    = 1'b1;
                div_ctl.short_op = 1'b1;
                div_dividend     = RW'(lo_reg);
                div_divisor      = DIVW'(fac_cur);
                state_next       = S_I_P;
            end

            S_I_P:
            begin
                if (div_done)
                begin
                    hi_next    = LEN_BITS'(div_quo);
                    lo_next    = LEN_BITS'(div_rem);
                    state_next = S_I_ACC;
                end
            end

            S_I_ACC:
            begin
                acc_next  = acc_reg + RW'(lo_reg) * wl_reg;
                nacc_next = nacc_reg + RW'(hi_reg) * wn_reg;
                wl_next   = wl_reg * RW'(fac_cur);
                wn_next   = wn_reg * RW'(q_cur);
                if (dim_reg == last_dim)
                begin
                    state_next = S_I_FIN;
                end
                else
                begin
                    dim_next   = dim_reg + DIM_W'(1);
                    state_next = S_I_L_GO;
                end
            end

            S_I_FIN:
            begin
                // Node part weighted by the full on-node count, then the on-node part.
                acc_next   = acc_reg + wl_reg * nacc_reg;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.rank_out      = err_reg ? '0 : acc_reg;
                    rsp_data_next.config_error  = err_reg;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        err_reg    <= err_next;
        dim_reg    <= dim_next;
        rank_reg   <= rank_next;
        prod_reg   <= prod_next;
        nl_reg     <= nl_next;
        node_reg   <= node_next;
        loc_reg    <= loc_next;
        acc_reg    <= acc_next;
        nacc_reg   <= nacc_next;
        wl_reg     <= wl_next;
        wn_reg     <= wn_next;
        stride_reg <= stride_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        digit_reg  <= digit_next;
        if (q_we)
        begin
            q_reg[dim_reg] <= LEN_BITS'(div_quo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_used_reg          <= trnr_pkg::RST_DIMS_USED;
            dim_lengths_reg        <= trnr_pkg::RST_LENGTHS;
            node_local_lengths_reg <= trnr_pkg::RST_LENGTHS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                trnr_pkg::REG_DIMS_USED:
                begin
                    dims_used_reg <= cfg_data[trnr_pkg::DU_W-1:0];
                end
                trnr_pkg::REG_DIM_LENGTHS:
                begin
                    dim_lengths_reg <= cfg_data;
                end
                trnr_pkg::REG_NODE_LOCAL_LENGTHS:
                begin
                    node_local_lengths_reg <= cfg_data;
                end
                default:
                begin
                    dims_used_reg <= dims_used_reg;
                end
            endcase
        end
    end

endmodule

// ===== verif/trnr_remap_checker.sv =====
// Checker that predicts and compares the remapped ranks of the torus rank node reorder block.
`timescale 1ns / 100ps

module trnr_remap_checker #(
    parameter int MAX_DIMS  = 8,
    parameter int LEN_BITS  = 8,
    parameter int RANK_BITS = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  trnr_pkg::req_t                 req_data,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  trnr_pkg::rsp_t                 rsp_data,
    input  logic                           cfg_we,
    input  logic [trnr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [trnr_pkg::CFG_W-1:0]     cfg_data,
    output int                             mismatch_count,
    output int                             outstanding
);

    localparam int          MAX_REPORTS = 10;
    localparam logic [63:0] LEN_MASK    = (64'd1 << LEN_BITS) - 64'd1;
    localparam logic [63:0] RANK_LIMIT  = 64'd1 << RANK_BITS;

    // Shadow copies of the register file and the derived stride table.
    logic [trnr_pkg::DU_W-1:0]   torus_dims;
    logic [trnr_pkg::CFG_W-1:0]  torus_lengths;
    logic [trnr_pkg::CFG_W-1:0]  local_lengths;
    logic [trnr_pkg::RANK_W-1:0] dim_stride [MAX_DIMS];

    trnr_pkg::rsp_t expected_remaps [$];

    function automatic logic [63:0] len_at(logic [63:0] packed_lens, int i);
        return (packed_lens >> (8 * i)) & LEN_MASK;
    endfunction

    function automatic logic [trnr_pkg::RANK_W-1:0] stride_of(logic [63:0] packed_lens, int k);
        logic [63:0] s;
        int          j;
        s = 64'd1;
        for (j = 0; j < k; j++)
        begin
            s = s * len_at(packed_lens, j);
            if (s > 64'(trnr_pkg::STRIDE_SAT))
                s = 64'(trnr_pkg::STRIDE_SAT);
        end
        return s[trnr_pkg::RANK_W-1:0];
    endfunction

    function automatic trnr_pkg::rsp_t predict_remap(logic cmd,
                                                     logic [trnr_pkg::RANK_W-1:0] rank);
        int unsigned    n;
        int             i;
        logic [63:0]    l, p, q, prod, num_local, acc, loc, node, r, w_node, w_loc;
        logic           bad;
        trnr_pkg::rsp_t res;
        n = (torus_dims == '0) ? 1 :
            ((int'(torus_dims) > MAX_DIMS) ? MAX_DIMS : int'(torus_dims));
        prod      = 64'd1;
        num_local = 64'd1;
        acc       = 64'd0;
        bad       = 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (!bad)
            begin
                l = len_at(torus_lengths, i);
                p = len_at(local_lengths, i);
                if (l == 0 || p == 0 || (l % p) != 0)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    prod      = prod * l;
                    num_local = num_local * p;
                    if (prod > RANK_LIMIT)
                        bad = 1'b1;
                end
            end
        end
        if (!bad && 64'(rank) >= prod)
            bad = 1'b1;
        if (!bad)
        begin
            if (cmd == trnr_pkg::CMD_FORWARD)
            begin
                loc  = 64'(rank) % num_local;
                node = 64'(rank) / num_local;
                for (i = 0; i < n; i++)
                begin
                    l    = len_at(torus_lengths, i);
                    p    = len_at(local_lengths, i);
                    q    = l / p;
                    acc  = acc + ((node % q) * p + (loc % p)) * 64'(dim_stride[i]);
                    node = node / q;
                    loc  = loc / p;
                end
            end
            else
            begin
                r      = 64'(rank);
                loc    = 64'd0;
                node   = 64'd0;
                w_node = 64'd1;
                w_loc  = 64'd1;
                for (i = 0; i < n; i++)
                begin
                    l      = len_at(torus_lengths, i);
                    p      = len_at(local_lengths, i);
                    loc    = loc + (r % p) * w_loc;
                    node   = node + ((r % l) / p) * w_node;
                    r      = r / l;
                    w_node = w_node * (l / p);
                    w_loc  = w_loc * p;
                end
                acc = loc + w_loc * node;
            end
        end
        res.rank_out     = bad ? '0 : acc[trnr_pkg::RANK_W-1:0];
        res.config_error = bad;
        return res;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        trnr_pkg::rsp_t want;
        int             k;
        if (!rst_n)
        begin
            torus_dims     = trnr_pkg::RST_DIMS_USED;
            torus_lengths  = trnr_pkg::RST_LENGTHS;
            local_lengths  = trnr_pkg::RST_LENGTHS;
            for (k = 0; k < MAX_DIMS; k++)
                dim_stride[k] = stride_of(trnr_pkg::RST_LENGTHS, k);
            expected_remaps.delete();
            outstanding    = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    trnr_pkg::REG_DIMS_USED:
                    begin
                        torus_dims = cfg_data[trnr_pkg::DU_W-1:0];
                    end
                    trnr_pkg::REG_DIM_LENGTHS:
                    begin
                        torus_lengths = cfg_data;
                        for (k = 0; k < MAX_DIMS; k++)
                            dim_stride[k] = stride_of(cfg_data, k);
                    end
                    trnr_pkg::REG_NODE_LOCAL_LENGTHS:
                    begin
                        local_lengths = cfg_data;
                    end
                    default: ;
                endcase
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_remaps.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result rank_out=%05h config_error=%0b",
                                            rsp_data.rank_out, rsp_data.config_error));
                end
                else
                begin
                    want = expected_remaps.pop_front();
                    outstanding--;
                    if (rsp_data.rank_out !== want.rank_out ||
                        rsp_data.config_error !== want.config_error)
                        flag_mismatch($sformatf(
                            "rank_out exp %05h got %05h, config_error exp %0b got %0b",
                            want.rank_out, rsp_data.rank_out,
                            want.config_error, rsp_data.config_error));
                end
            end
            if (req_valid && !req_stall)
            begin
                expected_remaps = {expected_remaps,
                                   predict_remap(req_data.command, req_data.rank_in)};
                outstanding++;
            end
        end
    end

endmodule

// ===== verif/torus_rank_node_reorder_tb.sv =====
// Testbench top for the torus rank node reorder block: stimulus, pacing and verdict.
`timescale 1ns / 100ps

module torus_rank_node_reorder_tb;

    // Index 3 has no register behind it; writes there must leave the block unchanged.
    localparam logic [trnr_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam int RANDOM_ITEMS = 1500;
    // Length of the one long output hold-off that backs the block up.
    localparam int HOLD_CYCLES  = 4000;
    // Quiet stretch after the last result, longer than one eight-dimension forward
    // request, so it leaves one full request of slack.
    localparam int QUIET_CYCLES = 600;

    logic                           clk;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_stall;
    trnr_pkg::req_t                 req_data;
    logic                           rsp_valid;
    logic                           rsp_stall;
    trnr_pkg::rsp_t                 rsp_data;
    logic                           cfg_we;
    logic [trnr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [trnr_pkg::CFG_W-1:0]     cfg_data;

    int mismatch_count;
    int outstanding;

    // Pacing knobs shared by the sender and the receiver, in percent per cycle.
    int tx_idle_pct;
    int rx_stall_pct;
    bit hold_req;

    int fwd_count;
    int inv_count;
    int settings_count;

    torus_rank_node_reorder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    trnr_remap_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_data       (rsp_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run is bounded by a fixed time well above the slowest legal run.
    initial
    begin
        #40_000_000;
        $display("Timeout: the run did not finish in time.");
        $display("DONE: errors detected");
        $finish;
    end

    // The receiver updates its stall at each falling edge. A single hold-off request
    // from the stimulus turns into a long stall that is counted here, so the block
    // fills its output register and then stalls new requests.
    initial
    begin : rx_pacing
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_seen)
            begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99, 0) < rx_stall_pct);
            end
        end
    end

    // Offers one request and returns at the falling edge after it was accepted, with
    // valid still high so that a following request can be offered without a gap.
    task automatic send_remap(input logic cmd, input logic [trnr_pkg::RANK_W-1:0] rank);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid        <= 1'b1;
        req_data.command <= cmd;
        req_data.rank_in <= rank;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        if (cmd == trnr_pkg::CMD_FORWARD)
            fwd_count++;
        else
            inv_count++;
    endtask

    // One register write; the enable drops for a cycle so back-to-back writes never
    // lower and raise it in the same step.
    task automatic write_reg(input logic [trnr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [trnr_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Stops offering requests and waits until every request has its result back.
    // Each request yields exactly one result, so the block is idle from then on.
    task automatic drain_remaps();
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Installs a torus setting once the block is idle. Now and then a write to the
    // unmapped index is mixed in, which must have no effect.
    task automatic load_torus(input logic [trnr_pkg::CFG_W-1:0] du_word,
                              input logic [trnr_pkg::CFG_W-1:0] lens,
                              input logic [trnr_pkg::CFG_W-1:0] locs);
        drain_remaps();
        write_reg(trnr_pkg::REG_DIMS_USED, du_word);
        write_reg(trnr_pkg::REG_DIM_LENGTHS, lens);
        if ($urandom_range(3, 0) == 0)
            write_reg(REG_UNMAPPED, {$urandom, $urandom});
        write_reg(trnr_pkg::REG_NODE_LOCAL_LENGTHS, locs);
        settings_count++;
    endtask

    // Builds a random torus. Most use few dimensions to keep requests short. A sound
    // torus has every on-node factor dividing its length and a product that fits the
    // rank range; a broken one carries one kind of flaw. span is the rank range of a
    // sound torus and the full 20-bit range otherwise.
    task automatic pick_torus(output logic [trnr_pkg::CFG_W-1:0] du_word,
                              output logic [trnr_pkg::CFG_W-1:0] lens,
                              output logic [trnr_pkg::CFG_W-1:0] locs,
                              output logic [63:0] span,
                              output bit sound);
        int          n;
        int          i;
        int          at;
        int unsigned maxl;
        int unsigned l;
        int unsigned p;
        n    = ($urandom_range(99, 0) < 80) ? $urandom_range(4, 1) : $urandom_range(8, 5);
        lens = {$urandom, $urandom};
        locs = {$urandom, $urandom};
        span = 64'd1;
        for (i = 0; i < n; i++)
        begin
            maxl = 32'((64'd1 << trnr_pkg::RANK_W) / span);
            if (maxl > 255)
                maxl = 255;
            l = $urandom_range(maxl, 1);
            p = $urandom_range(l, 1);
            while ((l % p) != 0)
                p--;
            lens[8*i +: 8] = l[7:0];
            locs[8*i +: 8] = p[7:0];
            span = span * l;
        end
        sound = ($urandom_range(99, 0) >= 20);
        if (!sound)
        begin
            at = $urandom_range(n - 1, 0);
            case ($urandom_range(3, 0))
                0: lens[8*at +: 8] = 8'd0;
                1: locs[8*at +: 8] = 8'd0;
                // A factor above its length never divides it; 2 does not divide 255.
                2: locs[8*at +: 8] = (lens[8*at +: 8] == 8'd255) ? 8'd2 : lens[8*at +: 8] + 8'd1;
                default:
                begin
                    n = $urandom_range(8, 3);
                    for (i = 0; i < n; i++)
                    begin
                        lens[8*i +: 8] = 8'd255;
                        locs[8*i +: 8] = 8'd1;
                    end
                end
            endcase
            span = 64'd1 << trnr_pkg::RANK_W;
        end
        // The count register keeps only its low nibble; junk above must not matter.
        du_word = {$urandom, $urandom};
        du_word[trnr_pkg::DU_W-1:0] = n[trnr_pkg::DU_W-1:0];
        if (n == 1 && $urandom_range(1, 0))
            du_word[trnr_pkg::DU_W-1:0] = '0;
        if (n == 8 && $urandom_range(1, 0))
            du_word[trnr_pkg::DU_W-1:0] = trnr_pkg::DU_W'($urandom_range(15, 9));
    endtask

    initial
    begin : stimulus
        logic [trnr_pkg::CFG_W-1:0]  du_word;
        logic [trnr_pkg::CFG_W-1:0]  lens;
        logic [trnr_pkg::CFG_W-1:0]  locs;
        logic [63:0]                 span;
        logic [trnr_pkg::RANK_W-1:0] rank;
        bit                          sound;
        int                          random_sent;
        int                          segment;
        int                          seg_items;
        int                          sel;
        int                          j;

        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_data       = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_req       = 1'b0;
        fwd_count      = 0;
        inv_count      = 0;
        settings_count = 0;
        random_sent    = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: one dimension of length one, so only rank zero is in range.
        send_remap(trnr_pkg::CMD_FORWARD, 20'h00000);
        send_remap(trnr_pkg::CMD_INVERSE, 20'h00000);
        send_remap(trnr_pkg::CMD_FORWARD, 20'hFFFFF);

        // A write to the unmapped index must leave the reset setting in place.
        drain_remaps();
        write_reg(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_remap(trnr_pkg::CMD_FORWARD, 20'h00000);

        // Five dimensions of sixteen fill the rank range exactly. Bytes above the
        // used dimensions carry junk that must be ignored.
        load_torus(64'd5, 64'hA5_3C_00_10_10_10_10_10, 64'h77_00_FF_01_10_08_04_02);
        send_remap(trnr_pkg::CMD_FORWARD, 20'h00000);
        send_remap(trnr_pkg::CMD_FORWARD, 20'hFFFFF);
        send_remap(trnr_pkg::CMD_FORWARD, 20'h55555);
        send_remap(trnr_pkg::CMD_INVERSE, 20'hFFFFF);
        send_remap(trnr_pkg::CMD_INVERSE, 20'hAAAAA);
        send_remap(trnr_pkg::CMD_INVERSE, 20'h12345);

        // A dimension count of zero behaves as one dimension.
        load_torus(64'hDEAD_BEEF_0000_0000, 64'h0000_0000_0000_00C8, 64'h0000_0000_0000_0008);
        send_remap(trnr_pkg::CMD_FORWARD, 20'd199);
        send_remap(trnr_pkg::CMD_INVERSE, 20'd137);
        send_remap(trnr_pkg::CMD_FORWARD, 20'd200);

        // A count above the maximum behaves as all eight dimensions.
        load_torus(64'd12, 64'h0404_0404_0404_0404, 64'h0202_0202_0202_0202);
        send_remap(trnr_pkg::CMD_FORWARD, 20'h0FFFF);
        send_remap(trnr_pkg::CMD_INVERSE, 20'h09C3A);
        send_remap(trnr_pkg::CMD_FORWARD, 20'h10000);

        // Broken factors: a zero length, a zero on-node factor, a non-divisor.
        load_torus(64'd3, 64'h0000_0000_0006_0004, 64'h0000_0000_0003_0102);
        send_remap(trnr_pkg::CMD_FORWARD, 20'd5);
        load_torus(64'd3, 64'h0000_0000_0006_0504, 64'h0000_0000_0000_0102);
        send_remap(trnr_pkg::CMD_INVERSE, 20'd7);
        load_torus(64'd3, 64'h0000_0000_0006_0504, 64'h0000_0000_0004_0102);
        send_remap(trnr_pkg::CMD_FORWARD, 20'd3);

        // Products above the rank range: far above, and just above.
        load_torus(64'd3, 64'h0000_0000_00FF_FFFF, 64'h0000_0000_0005_0311);
        send_remap(trnr_pkg::CMD_FORWARD, 20'd1);
        load_torus(64'd5, 64'h0000_0011_1010_1010, 64'h0000_0001_0101_0101);
        send_remap(trnr_pkg::CMD_INVERSE, 20'd0);

        // Random part: each segment installs a fresh torus and takes the next of the four
        // pacing modes. Most requests carry ranks inside the torus so that the full
        // digit arithmetic runs; the rest probe the boundary and the whole field.
        segment = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick_torus(du_word, lens, locs, span, sound);
            load_torus(du_word, lens, locs);
            case (segment % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 66;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 66;
                end
                default:
                begin
                    tx_idle_pct  = 24;
                    rx_stall_pct = 24;
                end
            endcase
            // Early on the receiver holds off for a long stretch while requests
            // keep coming, which backs the block up into its input.
            if (segment == 4)
                hold_req = 1'b1;
            seg_items = $urandom_range(60, 20);
            for (j = 0; j < seg_items; j++)
            begin
                sel = $urandom_range(99, 0);
                if (!sound || sel >= 92)
                    rank = trnr_pkg::RANK_W'($urandom_range(32'hFFFFF, 0));
                else if (sel >= 86)
                    case ($urandom_range(2, 0))
                        0: rank = '0;
                        1: rank = trnr_pkg::RANK_W'(span - 64'd1);
                        default: rank = trnr_pkg::RANK_W'(span);
                    endcase
                else
                    rank = trnr_pkg::RANK_W'($urandom_range(32'(span - 64'd1), 0));
                send_remap($urandom_range(1, 0) ? trnr_pkg::CMD_INVERSE : trnr_pkg::CMD_FORWARD,
                           rank);
                random_sent++;
            end
            segment++;
        end

        drain_remaps();
        repeat (QUIET_CYCLES) @(negedge clk);

        $display("Covered %0d remap requests (%0d forward, %0d inverse) over %0d torus settings,",
                 fwd_count + inv_count, fwd_count, inv_count, settings_count);
        $display("with four pacing modes and one %0d-cycle result hold-off; %0d mismatches.",
                 HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/trnr_pkg.sv
rtl/trnr_div.sv
rtl/torus_rank_node_reorder.sv
verif/trnr_remap_checker.sv
verif/torus_rank_node_reorder_tb.sv
